FILE: src/vhps_pkg.sv
// vhps_pkg: shared constants, command/status types and the cordic angle table
// for the vision heading pd steering block
// no dependencies
package vhps_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 16;
	localparam int DIV_STEPS    = 14;
	localparam int STEP_W       = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_YAW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEAD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OMEGA_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT   = 3'd7;

	localparam logic signed [15:0] INVALID_CODE = 16'sh8000;

	localparam logic signed [22:0] HE_MUL    = 23'sd2928177;
	localparam logic signed [30:0] BEAR_MUL  = 31'sd411774832;
	localparam logic signed [24:0] STEER_MUL = 25'sd12015796;
	localparam logic signed [33:0] INV_GAIN  = 34'sd652032874;
	localparam logic [11:0]        DIV_DEN   = 12'd1125;
	localparam logic [26:0]        DIV_BIAS  = 27'd562;

	typedef struct packed {
		logic              load;
		logic              sq;
		logic              sum;
		logic              sqrt_step;
		logic              dist_fin;
		logic              cordic_step;
		logic              sin_mode;
		logic              bear;
		logic              lat;
		logic              filt;
		logic              acc;
		logic              acc_sum;
		logic              omega;
		logic              st_mul;
		logic              steer;
		logic              out_load;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic reject;
	} sts_t;

	// arctangent of 2^-i in binary angle units, 2^32 per turn
	function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/vhps_ctrl.sv
// vhps_ctrl: sequencer for the steering datapath, owns both handshakes
// depends on vhps_pkg
module vhps_ctrl import vhps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SQ      = 4'd1;
	localparam logic [3:0] S_SUM     = 4'd2;
	localparam logic [3:0] S_SQRT    = 4'd3;
	localparam logic [3:0] S_DIST    = 4'd4;
	localparam logic [3:0] S_ATAN    = 4'd5;
	localparam logic [3:0] S_BEAR    = 4'd6;
	localparam logic [3:0] S_SIN     = 4'd7;
	localparam logic [3:0] S_LAT     = 4'd8;
	localparam logic [3:0] S_FILT    = 4'd9;
	localparam logic [3:0] S_ACC     = 4'd10;
	localparam logic [3:0] S_ACCSUM  = 4'd11;
	localparam logic [3:0] S_OMEGA   = 4'd12;
	localparam logic [3:0] S_STMUL   = 4'd13;
	localparam logic [3:0] S_STEER   = 4'd14;
	localparam logic [3:0] S_DONE    = 4'd15;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q;
	logic              out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd      = '0;
		cmd.step = cnt_q;
		state_d  = state_q;
		cnt_d    = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_DIST;
				end
			end
			S_DIST: begin
				cmd.dist_fin = 1'b1;
				state_d      = sts.reject ? S_DONE : S_ATAN;
			end
			S_ATAN: begin
				cmd.cordic_step = 1'b1;
				cnt_d           = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_BEAR;
				end
			end
			S_BEAR: begin
				cmd.bear = 1'b1;
				state_d  = S_SIN;
			end
			S_SIN: begin
				cmd.cordic_step = 1'b1;
				cmd.sin_mode    = 1'b1;
				cnt_d           = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_LAT;
				end
			end
			S_LAT: begin
				cmd.lat = 1'b1;
				state_d = S_FILT;
			end
			S_FILT: begin
				cmd.filt = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_ACCSUM;
			end
			S_ACCSUM: begin
				cmd.acc_sum = 1'b1;
				state_d     = S_OMEGA;
			end
			S_OMEGA: begin
				cmd.omega = 1'b1;
				state_d   = S_STMUL;
			end
			S_STMUL: begin
				cmd.st_mul = 1'b1;
				state_d    = S_STEER;
			end
			S_STEER: begin
				cmd.steer = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/vhps_dp.sv
// vhps_dp: config registers, square root and angle divider, shared cordic unit,
// filter state, pd sum and the output register
// depends on vhps_pkg
module vhps_dp import vhps_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [15:0]          target_x_mm,
	input  logic signed [15:0]          target_y_mm,
	input  logic signed [15:0]          yaw_centideg,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	output logic                        valid_res,
	output logic signed [15:0]          yaw_rate_cmd_mrad_s,
	output logic signed [15:0]          steer_err_centideg,
	output logic signed [16:0]          lateral_error_mm,
	output logic signed [12:0]          heading_error_mrad,
	output logic signed [12:0]          bearing_mrad,
	output logic [15:0]                 distance_mm,
	output logic signed [15:0]          heading_rate_mrad
);

	// round half away from zero, then arithmetic shift
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
		input int unsigned s);
		logic signed [63:0] h;
		h = 64'sd1 <<< (s - 1);
		return (v + h - $signed({63'd0, v[63]})) >>> s;
	endfunction

	function automatic logic signed [16:0] wrap1(input logic signed [16:0] v);
		logic signed [16:0] r;
		r = v;
		if (v > 17'sd18000) begin
			r = v - 17'sd36000;
		end else if (v < -17'sd18000) begin
			r = v + 17'sd36000;
		end
		return r;
	endfunction

	// config
	logic signed [15:0] entry_q, gh_q, ghr_q, gl_q;
	logic [15:0]        alpha_q, range_q;
	logic [14:0]        om_lim_q, err_lim_q;

	// filter state
	logic signed [12:0] prev_q;
	logic signed [31:0] f_q;
	logic               have_prev_q;

	// item registers
	logic signed [15:0] x_q, y_q;
	logic signed [16:0] d_q;
	logic               invalid_q, zero_q, dneg_q, reject_q, sneg_q;
	logic [31:0]        xx_q, yy_q, n_q;
	logic signed [39:0] he_prod_q;
	logic signed [12:0] he_q;
	logic [15:0]        sr_q, dist_q;
	logic [17:0]        srem_q;
	logic [41:0]        dm_q;
	logic [10:0]        drem_q;
	logic [31:0]        dq_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [32:0] fdelta_q;
	logic signed [61:0] bprod_q;
	logic signed [50:0] latprod_q;
	logic signed [49:0] fprod_q;
	logic signed [16:0] lat_q;
	logic signed [28:0] p1_q;
	logic signed [32:0] p2_q;
	logic signed [47:0] p3_q;
	logic signed [49:0] acc_q;
	logic signed [15:0] omega_q, steer_q;
	logic signed [41:0] stprod_q;

	// combinational helpers
	logic signed [16:0] d_c;
	logic [19:0]        rem_sh, trial;
	logic [10:0]        drem_c;
	logic [2:0]         dbits_c;
	logic [11:0]        dt;
	logic [15:0]        dist_c;
	logic signed [33:0] xs, ys, tab;
	logic               ccw;
	logic [31:0]        zb, hb_s, ang, ang2;
	logic signed [33:0] sinv;
	logic signed [13:0] dh;
	logic signed [63:0] om_r, st_r;
	logic signed [15:0] om_c, st_c;

	assign d_c = wrap1(wrap1($signed({entry_q[15], entry_q}) -
		$signed({yaw_centideg[15], yaw_centideg})));

	// one bit of root per step
	assign rem_sh = {srem_q, n_q[31:30]};
	assign trial  = {2'b00, sr_q, 2'b01};

	// three quotient bits per step of the angle division by 1125
	always_comb begin
		drem_c = drem_q;
		dt     = '0;
		for (int k = 0; k < 3; k++) begin
			dt = {drem_c, dm_q[41-k]};
			if (dt >= DIV_DEN) begin
				dt         = dt - DIV_DEN;
				dbits_c[2-k] = 1'b1;
			end else begin
				dbits_c[2-k] = 1'b0;
			end
			drem_c = dt[10:0];
		end
	end

	assign dist_c = sr_q + 16'(srem_q > {2'b00, sr_q});
	assign sts.reject = invalid_q || (dist_c > range_q);

	// cordic step, vectoring for atan2 and rotation for sine
	assign xs  = cx_q >>> cmd.step;
	assign ys  = cy_q >>> cmd.step;
	assign tab = $signed({2'b00, atan_bam(cmd.step)});
	assign ccw = cmd.sin_mode ? !cz_q[33] : !(cy_q > 34'sd0);

	assign zb   = zero_q ? 32'd0 : cz_q[31:0];
	assign hb_s = dneg_q ? (32'd0 - dq_q) : dq_q;
	assign ang  = zb - hb_s;
	assign ang2 = ang + 32'h8000_0000;
	assign sinv = sneg_q ? -cy_q : cy_q;
	assign dh   = $signed({he_q[12], he_q}) - $signed({prev_q[12], prev_q});

	always_comb begin
		om_r = rnd_sh(64'(acc_q), 24);
		if (om_r > $signed({49'd0, om_lim_q})) begin
			om_c = $signed({1'b0, om_lim_q});
		end else if (om_r < -$signed({49'd0, om_lim_q})) begin
			om_c = -$signed({1'b0, om_lim_q});
		end else begin
			om_c = om_r[15:0];
		end
		st_r = rnd_sh(64'(stprod_q), 24);
		if (st_r > $signed({49'd0, err_lim_q})) begin
			st_c = $signed({1'b0, err_lim_q});
		end else if (st_r < -$signed({49'd0, err_lim_q})) begin
			st_c = -$signed({1'b0, err_lim_q});
		end else begin
			st_c = st_r[15:0];
		end
	end

	// config and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q     <= '0;
			gh_q        <= '0;
			ghr_q       <= '0;
			gl_q        <= '0;
			alpha_q     <= 16'hFFFF;
			range_q     <= 16'd2000;
			om_lim_q    <= 15'd32767;
			err_lim_q   <= 15'd18000;
			prev_q      <= '0;
			f_q         <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ENTRY_YAW: begin
						entry_q     <= $signed(cfg_data);
						prev_q      <= '0;
						f_q         <= '0;
						have_prev_q <= 1'b0;
					end
					REG_GAIN_HEAD:   gh_q      <= $signed(cfg_data);
					REG_GAIN_RATE:   ghr_q     <= $signed(cfg_data);
					REG_GAIN_LAT:    gl_q      <= $signed(cfg_data);
					REG_ALPHA:       alpha_q   <= cfg_data;
					REG_RANGE:       range_q   <= cfg_data;
					REG_OMEGA_LIMIT: om_lim_q  <= cfg_data[14:0];
					REG_ERR_LIMIT:   err_lim_q <= cfg_data[14:0];
					default: begin
					end
				endcase
			end else if (cmd.filt) begin
				if (have_prev_q) begin
					f_q <= f_q + 32'(rnd_sh(64'(fprod_q), 16));
				end
				prev_q      <= he_q;
				have_prev_q <= 1'b1;
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= target_x_mm;
			y_q       <= target_y_mm;
			d_q       <= d_c;
			invalid_q <= (target_x_mm == INVALID_CODE) || (target_y_mm == INVALID_CODE);
		end
		if (cmd.sq) begin
			xx_q      <= 32'(x_q * x_q);
			yy_q      <= 32'(y_q * y_q);
			he_prod_q <= d_q * HE_MUL;
			dneg_q    <= d_q[16];
			dm_q      <= {d_q[16] ? 15'(-d_q) : d_q[14:0], DIV_BIAS};
			drem_q    <= '0;
			dq_q      <= '0;
		end
		if (cmd.sum) begin
			n_q    <= xx_q + yy_q;
			sr_q   <= '0;
			srem_q <= '0;
			he_q   <= 13'(rnd_sh(64'(he_prod_q), 24));
		end
		if (cmd.sqrt_step) begin
			n_q <= {n_q[29:0], 2'b00};
			if (rem_sh >= trial) begin
				srem_q <= 18'(rem_sh - trial);
				sr_q   <= {sr_q[14:0], 1'b1};
			end else begin
				srem_q <= rem_sh[17:0];
				sr_q   <= {sr_q[14:0], 1'b0};
			end
			if (cmd.step < STEP_W'(DIV_STEPS)) begin
				dm_q   <= {dm_q[38:0], 3'b000};
				drem_q <= drem_c;
				dq_q   <= {dq_q[28:0], dbits_c};
			end
		end
		if (cmd.dist_fin) begin
			dist_q   <= dist_c;
			reject_q <= sts.reject;
			zero_q   <= (x_q == 16'sd0) && (y_q == 16'sd0);
			fdelta_q <= $signed({dh, 16'd0}) - 33'(f_q);
			if (y_q[15]) begin
				cx_q <= -$signed({{4{y_q[15]}}, y_q, 14'd0});
				cy_q <= -$signed({{4{x_q[15]}}, x_q, 14'd0});
				cz_q <= 34'sh0_8000_0000;
			end else begin
				cx_q <= $signed({{4{y_q[15]}}, y_q, 14'd0});
				cy_q <= $signed({{4{x_q[15]}}, x_q, 14'd0});
				cz_q <= '0;
			end
		end
		if (cmd.cordic_step) begin
			if (ccw) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - tab;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + tab;
			end
		end
		if (cmd.bear) begin
			bprod_q <= $signed(zb) * BEAR_MUL;
			cx_q    <= INV_GAIN;
			cy_q    <= '0;
			// fold the angle into the right half plane
			if ($signed(ang) > 32'sh4000_0000 || $signed(ang) < -32'sh4000_0000) begin
				cz_q   <= 34'($signed(ang2));
				sneg_q <= 1'b1;
			end else begin
				cz_q   <= 34'($signed(ang));
				sneg_q <= 1'b0;
			end
		end
		if (cmd.lat) begin
			latprod_q <= $signed({1'b0, dist_q}) * sinv;
			fprod_q   <= $signed({1'b0, alpha_q}) * fdelta_q;
		end
		if (cmd.filt) begin
			lat_q <= 17'(rnd_sh(64'(latprod_q), 30));
		end
		if (cmd.acc) begin
			p1_q <= gh_q * he_q;
			p2_q <= gl_q * lat_q;
			p3_q <= ghr_q * f_q;
		end
		if (cmd.acc_sum) begin
			acc_q <= $signed({p1_q, 16'd0}) + $signed({p2_q, 16'd0}) + 50'(p3_q);
		end
		if (cmd.omega) begin
			omega_q <= om_c;
		end
		if (cmd.st_mul) begin
			stprod_q <= (-$signed({omega_q[15], omega_q})) * STEER_MUL;
		end
		if (cmd.steer) begin
			steer_q <= st_c;
		end
		if (cmd.out_load) begin
			if (reject_q) begin
				valid_res           <= 1'b0;
				yaw_rate_cmd_mrad_s <= '0;
				steer_err_centideg  <= '0;
				lateral_error_mm    <= '0;
				heading_error_mrad  <= '0;
				bearing_mrad        <= '0;
				distance_mm         <= '0;
				heading_rate_mrad   <= '0;
			end else begin
				valid_res           <= 1'b1;
				yaw_rate_cmd_mrad_s <= omega_q;
				steer_err_centideg  <= steer_q;
				lateral_error_mm    <= lat_q;
				heading_error_mrad  <= he_q;
				bearing_mrad        <= 13'(rnd_sh(64'(bprod_q), 48));
				distance_mm         <= dist_q;
				heading_rate_mrad   <= 16'(rnd_sh(64'(f_q), 16));
			end
		end
	end

endmodule

FILE: src/vision_heading_pd_steer.sv
// vision_heading_pd_steer: pd yaw-rate controller fed by a vision target point
// top level, joins vhps_ctrl and vhps_dp; depends on vhps_pkg
// a valid point runs through the 16-step square root and the two 16-step passes
//   of the shared cordic unit before it shows on out_valid; a rejected point (marked
//   invalid or out of range) skips the cordic passes and the rest of the datapath
// one transaction at a time: in_stall stays high until the result is loaded for output
// reset: arst_n resets the sequencer, clears the filter state and sets the config registers to their defaults
module vision_heading_pd_steer import vhps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    target_x_mm,
	input  logic signed [15:0]    target_y_mm,
	input  logic signed [15:0]    yaw_centideg,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  valid_res,
	output logic signed [15:0]    yaw_rate_cmd_mrad_s,
	output logic signed [15:0]    steer_err_centideg,
	output logic signed [16:0]    lateral_error_mm,
	output logic signed [12:0]    heading_error_mrad,
	output logic signed [12:0]    bearing_mrad,
	output logic [15:0]           distance_mm,
	output logic signed [15:0]    heading_rate_mrad
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: one transaction at a time, output register freed by out_stall low
	vhps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: root and angle divider run together, then atan2 and sine on
	// one cordic unit, then filter, pd sum and clamps
	vhps_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_idx             (cfg_idx),
		.cfg_data            (cfg_data),
		.target_x_mm         (target_x_mm),
		.target_y_mm         (target_y_mm),
		.yaw_centideg        (yaw_centideg),
		.cmd                 (cmd),
		.sts                 (sts),
		.valid_res           (valid_res),
		.yaw_rate_cmd_mrad_s (yaw_rate_cmd_mrad_s),
		.steer_err_centideg  (steer_err_centideg),
		.lateral_error_mm    (lateral_error_mm),
		.heading_error_mrad  (heading_error_mrad),
		.bearing_mrad        (bearing_mrad),
		.distance_mm         (distance_mm),
		.heading_rate_mrad   (heading_rate_mrad)
	);

endmodule

FILE: sim/vhps_checker.sv
// vhps_checker: watches the input, output and config ports of the vision heading pd
// steering block, predicts each result and compares it field by field
// depends on vhps_pkg for the config port widths and register indexes
module vhps_checker import vhps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic signed [15:0]    target_x_mm,
	input  logic signed [15:0]    target_y_mm,
	input  logic signed [15:0]    yaw_centideg,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  valid_res,
	input  logic signed [15:0]    yaw_rate_cmd_mrad_s,
	input  logic signed [15:0]    steer_err_centideg,
	input  logic signed [16:0]    lateral_error_mm,
	input  logic signed [12:0]    heading_error_mrad,
	input  logic signed [12:0]    bearing_mrad,
	input  logic [15:0]           distance_mm,
	input  logic signed [15:0]    heading_rate_mrad,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        ok;
		logic [15:0] omega;
		logic [15:0] steer;
		logic [16:0] lat;
		logic [12:0] he;
		logic [12:0] bear;
		logic [15:0] dist_mm;
		logic [15:0] rate;
	} steer_result_t;

	localparam int unsigned ANGLE_STEP [0:15] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	steer_result_t results_due[$];
	longint entry_yaw, k_head, k_rate, k_lat, alpha, range_mm, omega_lim, err_lim;
	longint last_he, rate_acc;
	bit     primed;
	int     n_out;

	assign pending = results_due.size();

	function automatic longint round_shift(longint v, int s);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint unsigned root_rounded(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 32;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (n > r) r = r + 1;
		return r;
	endfunction

	// vectoring cordic, angle in 2^32 units per turn
	function automatic logic [31:0] point_angle(longint px, longint py);
		longint cx, cy, nx;
		logic [31:0] z;
		cx = py * 16384;
		cy = px * 16384;
		z = 0;
		if (px == 0 && py == 0) return 0;
		if (cx < 0) begin
			cx = -cx;
			cy = -cy;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (cy > 0) begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z = z + ANGLE_STEP[i];
			end else begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z = z - ANGLE_STEP[i];
			end
			cx = nx;
		end
		return z;
	endfunction

	// rotation cordic, sine in q30
	function automatic longint sine_q30(logic [31:0] a);
		longint s, cx, cy, nx;
		bit flip;
		s = longint'($signed(a));
		cx = 652032874;
		cy = 0;
		flip = 0;
		if (s > (64'sd1 << 30) || s < -(64'sd1 << 30)) begin
			a = a + 32'h8000_0000;
			s = longint'($signed(a));
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (s >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				s = s - ANGLE_STEP[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				s = s + ANGLE_STEP[i];
			end
			cx = nx;
		end
		return flip ? -cy : cy;
	endfunction

	function automatic steer_result_t steer_predict(longint px, longint py, longint yaw);
		steer_result_t r;
		longint d, he, bear, lat, omega, steer, dmag, acc, diff;
		longint unsigned tgt_dist;
		logic [31:0] zb, hb;
		r = '0;
		if (px == -32768 || py == -32768) return r;
		tgt_dist = root_rounded(longint'(px * px + py * py));
		if (tgt_dist > range_mm) return r;
		zb = point_angle(px, py);
		bear = round_shift(longint'($signed(zb)) * 411774832, 48);
		d = entry_yaw - yaw;
		while (d > 18000) d = d - 36000;
		while (d < -18000) d = d + 36000;
		he = round_shift(d * 2928177, 24);
		dmag = (d < 0) ? -d : d;
		hb = 32'(((dmag << 32) + 18000) / 36000);
		if (d < 0) hb = -hb;
		lat = round_shift(longint'(tgt_dist) * sine_q30(zb - hb), 30);
		if (primed) begin
			diff = (he - last_he) * 65536;
			rate_acc = rate_acc + round_shift(alpha * (diff - rate_acc), 16);
		end
		last_he = he;
		primed = 1;
		acc = k_head * he * 65536 + k_lat * lat * 65536 + k_rate * rate_acc;
		omega = clip(round_shift(acc, 24), omega_lim);
		steer = clip(round_shift(-omega * 12015796, 24), err_lim);
		r.ok      = 1'b1;
		r.omega   = omega[15:0];
		r.steer   = steer[15:0];
		r.lat     = lat[16:0];
		r.he      = he[12:0];
		r.bear    = bear[12:0];
		r.dist_mm = tgt_dist[15:0];
		r.rate    = 16'(round_shift(rate_acc, 16));
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d", n_out, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		steer_result_t e;
		if (!arst_n) begin
			entry_yaw = 0; k_head = 0; k_rate = 0; k_lat = 0;
			alpha = 65535; range_mm = 2000; omega_lim = 32767; err_lim = 18000;
			last_he = 0; rate_acc = 0; primed = 0;
			errors = 0; n_out = 0;
			results_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ENTRY_YAW: begin
						entry_yaw = longint'($signed(cfg_data));
						last_he = 0; rate_acc = 0; primed = 0;
					end
					REG_GAIN_HEAD:   k_head = longint'($signed(cfg_data));
					REG_GAIN_RATE:   k_rate = longint'($signed(cfg_data));
					REG_GAIN_LAT:    k_lat = longint'($signed(cfg_data));
					REG_ALPHA:       alpha = cfg_data;
					REG_RANGE:       range_mm = cfg_data;
					REG_OMEGA_LIMIT: omega_lim = cfg_data[14:0];
					REG_ERR_LIMIT:   err_lim = cfg_data[14:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				results_due.push_back(steer_predict(target_x_mm, target_y_mm, yaw_centideg));
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display("unexpected result %0d with nothing pending", n_out);
					errors++;
				end else begin
					e = results_due.pop_front();
					if (valid_res !== e.ok) report("valid_res", valid_res, e.ok);
					if (yaw_rate_cmd_mrad_s !== e.omega)
						report("yaw_rate", yaw_rate_cmd_mrad_s, $signed(e.omega));
					if (steer_err_centideg !== e.steer)
						report("steer_err", steer_err_centideg, $signed(e.steer));
					if (lateral_error_mm !== e.lat)
						report("lateral", lateral_error_mm, $signed(e.lat));
					if (heading_error_mrad !== e.he)
						report("heading_err", heading_error_mrad, $signed(e.he));
					if (bearing_mrad !== e.bear)
						report("bearing", bearing_mrad, $signed(e.bear));
					if (distance_mm !== e.dist_mm)
						report("distance", distance_mm, e.dist_mm);
					if (heading_rate_mrad !== e.rate)
						report("heading_rate", heading_rate_mrad, $signed(e.rate));
				end
				n_out++;
			end
		end
	end

endmodule

FILE: sim/vision_heading_pd_steer_tb.sv
// vision_heading_pd_steer_tb: stimulus and verdict for the vision heading pd block
// depends on vhps_pkg, vision_heading_pd_steer and vhps_checker
module vision_heading_pd_steer_tb import vhps_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 0;
	logic                  in_stall;
	logic signed [15:0]    target_x_mm = '0;
	logic signed [15:0]    target_y_mm = '0;
	logic signed [15:0]    yaw_centideg = '0;
	logic                  out_valid;
	logic                  out_stall = 0;
	logic                  valid_res;
	logic signed [15:0]    yaw_rate_cmd_mrad_s;
	logic signed [15:0]    steer_err_centideg;
	logic signed [16:0]    lateral_error_mm;
	logic signed [12:0]    heading_error_mrad;
	logic signed [12:0]    bearing_mrad;
	logic [15:0]           distance_mm;
	logic signed [15:0]    heading_rate_mrad;
	int                    errors;
	int                    pending;

	// sender burst bookkeeping, receiver long hold-off and watchdog
	int burst_left = 0;
	int hold_left = 0;
	bit hold_go = 0;
	bit hold_used = 0;
	int quiet_cycles = 0;
	int rx_cycle = 0;
	int cur_range = 2000;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 600;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	vision_heading_pd_steer dut (.*);

	vhps_checker chk (.*);

	// receiver: stall pattern picked by bits 9:8 of rx_cycle, with one long hold on request
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (hold_go && !hold_used) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			case (rx_cycle[9:8])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 99) < 30);
				2'd2: out_stall <= (rx_cycle % 3 == 0);
				default: out_stall <= ($urandom_range(0, 99) < 75);
			endcase
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_RANGE) cur_range = int'(val);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// idle margin before the next config writes
		repeat (80) @(posedge clk);
	endtask

	// one transaction on the input channel, then maybe a gap ending the burst
	task automatic send_point(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] yaw);
		in_valid     <= 1'b1;
		target_x_mm  <= px;
		target_y_mm  <= py;
		yaw_centideg <= yaw;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic load_config(logic [15:0] ey, logic [15:0] gh, logic [15:0] gr,
			logic [15:0] gl, logic [15:0] al, logic [15:0] rg, logic [15:0] ol,
			logic [15:0] el);
		write_reg(REG_ENTRY_YAW, ey);
		write_reg(REG_GAIN_HEAD, gh);
		write_reg(REG_GAIN_RATE, gr);
		write_reg(REG_GAIN_LAT, gl);
		write_reg(REG_ALPHA, al);
		write_reg(REG_RANGE, rg);
		write_reg(REG_OMEGA_LIMIT, ol);
		write_reg(REG_ERR_LIMIT, el);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_yaw();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 35999)) - 18000);
	endfunction

	// mostly points near the detect range, some sentinels and raw noise
	task automatic random_points(int count);
		int r, sel;
		logic signed [15:0] px, py;
		for (int n = 0; n < count; n++) begin
			r = (cur_range > 32767) ? 32767 : cur_range;
			sel = $urandom_range(0, 99);
			px = 16'($signed($urandom_range(0, 2 * r)) - r);
			py = 16'($signed($urandom_range(0, 2 * r)) - r);
			if (sel < 8) px = INVALID_CODE;
			else if (sel < 14) py = INVALID_CODE;
			else if (sel < 24) begin
				px = 16'($urandom);
				py = 16'($urandom);
			end
			send_point(px, py, pick_yaw());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sentinels, axes, range edge, zero vector, yaw extremes and wrap
		load_config(16'sd0, 16'sd256, 16'sd128, -16'sd5, 16'd40000, 16'd2000,
			16'd32767, 16'd18000);
		send_point(INVALID_CODE, 16'sd100, 16'sd0);
		send_point(16'sd100, INVALID_CODE, 16'sd0);
		send_point(16'sd0, 16'sd0, 16'sd0);
		send_point(16'sd2000, 16'sd0, 16'sd1000);
		send_point(16'sd2001, 16'sd0, 16'sd1000);
		send_point(16'sd0, -16'sd2000, -16'sd18000);
		send_point(-16'sd1, -16'sd1, 16'sd17999);
		send_point(16'sd1414, 16'sd1414, 16'sd32767);
		send_point(-16'sd1414, 16'sd1414, -16'sd32768);
		send_point(16'sd0, 16'sd1, 16'sd9000);
		send_point(16'sd0, -16'sd1, -16'sd9000);
		send_point(16'sd32767, 16'sd32767, 16'sd0);
		send_point(-16'sd32767, -16'sd32767, 16'sd0);
		wait_drained();

		// largest gains and range, full alpha, entry yaw at its low end
		load_config(-16'sd18000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff, 16'd46341,
			16'hffff, 16'd32767);
		send_point(16'sd32767, 16'sd32767, 16'sd17999);
		send_point(-16'sd32767, 16'sd32767, -16'sd18000);
		send_point(16'sd30000, -16'sd30000, 16'sd0);
		send_point(16'sd1, 16'sd0, 16'sd4500);
		random_points(160);
		wait_drained();

		// zero limits and zero alpha, entry yaw at its high end
		load_config(16'sd17999, 16'sh8000, 16'sh7fff, 16'sh8000, 16'd0, 16'd0,
			16'd0, 16'd0);
		send_point(16'sd0, 16'sd0, 16'sd100);
		send_point(16'sd1, 16'sd0, 16'sd100);
		random_points(60);
		wait_drained();

		// long receiver hold-off while the sender keeps offering points
		load_config(16'sd500, 16'sd300, -16'sd200, 16'sd40, 16'd20000, 16'd3000,
			16'd2000, 16'd18000);
		hold_go = 1'b1;
		random_points(200);
		wait_drained();

		// random settings for the rest
		for (int ph = 0; ph < 5; ph++) begin
			load_config(16'($signed($urandom_range(0, 35999)) - 18000), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(0, 46341)), 16'($urandom_range(0, 32767)),
				16'($urandom_range(0, 18000)));
			random_points(130);
			wait_drained();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
